// ===== rtl/psg_pkg.sv =====
// Shared types, constants and the attenuation level table of the sound generator.
package psg_pkg;

  // Kind of work an item carries from the front to the back.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_TONE,
    OP_NOISE,
    OP_ATTEN
  } op_kind_t;

  // Decoded item as it travels through the queue.
  typedef struct packed {
    op_kind_t    kind;
    logic        latch;  // latch byte: carries the low nibble of the register data
    logic [1:0]  chan;   // channel number for tone and attenuation writes
    logic [5:0]  value;  // low nibble on a latch byte, six data bits otherwise
  } op_t;

  localparam int unsigned TONE_W = 10;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned LFSR_W = 17;
  localparam int unsigned SAMPLE_W = 16;

  localparam logic [2:0] REG_NOISE = 3'd6;
  localparam logic [2:0] REG_TONE2 = 3'd4;

  localparam logic [1:0] NOISE_TIED = 2'd3;
  localparam logic [CNT_W-1:0] TONE_ZERO_PERIOD = 12'h400;
  localparam logic [CNT_W-1:0] NOISE_PER_32  = 12'd32;
  localparam logic [CNT_W-1:0] NOISE_PER_64  = 12'd64;
  localparam logic [CNT_W-1:0] NOISE_PER_128 = 12'd128;
  localparam logic [LFSR_W-1:0] NOISE_SEED = 17'h10000;

  // Output level for an attenuation step, 2 dB per step, step 15 silent.
  function automatic logic [12:0] level(input logic [3:0] att);
    logic [12:0] l;
    case (att)
      4'd0:    l = 13'd8191;
      4'd1:    l = 13'd6506;
      4'd2:    l = 13'd5168;
      4'd3:    l = 13'd4105;
      4'd4:    l = 13'd3260;
      4'd5:    l = 13'd2590;
      4'd6:    l = 13'd2057;
      4'd7:    l = 13'd1634;
      4'd8:    l = 13'd1298;
      4'd9:    l = 13'd1031;
      4'd10:   l = 13'd819;
      4'd11:   l = 13'd650;
      4'd12:   l = 13'd516;
      4'd13:   l = 13'd410;
      4'd14:   l = 13'd326;
      default: l = 13'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/psg_front.sv =====
// Front end: accepts items, resolves the register index and decodes them.
module psg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // write_data[7:0]
  input  logic [0:0]    s_tuser,   // mode[0]
  input  logic          q_full,
  output logic          push,
  output psg_pkg::op_t  op
);

  logic [2:0] latched_index;
  logic       latch;
  logic [2:0] r;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;
  assign latch    = s_tdata[7];
  assign r        = latch ? s_tdata[6:4] : latched_index;

  // Latched register index follows latch bytes in order of arrival
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_index <= 3'd0;
    end else if (push && s_tuser[0] && latch) begin
      latched_index <= s_tdata[6:4];
    end
  end

  // Classify the item
  always_comb begin
    op.latch = latch;
    op.chan  = r[2:1];
    op.value = latch ? {2'b00, s_tdata[3:0]} : s_tdata[5:0];
    if (!s_tuser[0]) begin
      op.kind = psg_pkg::OP_TICK;
    end else if (r[0]) begin
      op.kind = psg_pkg::OP_ATTEN;
    end else if (r == psg_pkg::REG_NOISE) begin
      op.kind = psg_pkg::OP_NOISE;
    end else begin
      op.kind = psg_pkg::OP_TONE;
    end
  end

endmodule

// ===== rtl/psg_queue.sv =====
// Small register queue between the decode front and the execute back.
module psg_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  psg_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          out_valid,
  output psg_pkg::op_t  out_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NUM_W = $clog2(DEPTH + 1);

  psg_pkg::op_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [NUM_W-1:0] count;

  assign full      = (count == NUM_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NUM_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_valid)
    else $error("pop from empty queue");

endmodule

// ===== rtl/psg_back.sv =====
// Back end: register writes, tone and noise counters, mixer and output register.
module psg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  psg_pkg::op_t                  q_op,
  output logic                          pop,
  input  logic                          negate_output,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psg_pkg::SAMPLE_W-1:0]  m_tdata    // sample[15:0]
);

  logic [psg_pkg::TONE_W-1:0] tone_period   [3];
  logic [psg_pkg::CNT_W-1:0]  reload_period [4];
  logic [psg_pkg::CNT_W-1:0]  down_counter  [4];
  logic [3:0]                 attenuation   [4];
  logic [3:0]                 channel_level;
  logic [3:0]                 noise_control;
  logic [psg_pkg::LFSR_W-1:0] noise_shift;

  logic                          is_tick;
  logic                          do_op;
  logic [3:0]                    fire;
  logic [psg_pkg::CNT_W-1:0]     cnt_next [4];
  logic [3:0]                    level_next;
  logic                          fb;
  logic [psg_pkg::LFSR_W-1:0]    shift_next;
  logic [psg_pkg::SAMPLE_W-1:0]  sum;
  logic [psg_pkg::TONE_W-1:0]    tone_next;
  logic [psg_pkg::CNT_W-1:0]     tone_reload;
  logic [psg_pkg::CNT_W-1:0]     noise_reload;

  assign is_tick = (q_op.kind == psg_pkg::OP_TICK);
  assign pop     = q_valid && (!is_tick || !m_tvalid || m_tready);
  assign do_op   = pop;

  // Counter step for a tick
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fire[i]     = (down_counter[i] <= psg_pkg::CNT_W'(1));
      cnt_next[i] = fire[i] ? reload_period[i] : down_counter[i] - 1'b1;
    end
    fb = noise_shift[2] ^ (noise_control[2] & noise_shift[3]);
    shift_next = fire[3] ? {fb, noise_shift[psg_pkg::LFSR_W-1:1]} : noise_shift;
    level_next[2:0] = channel_level[2:0] ^ fire[2:0];
    level_next[3]   = fire[3] ? shift_next[0] : channel_level[3];
  end

  // Mixer over the four new levels
  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (level_next[i]) begin
        sum = sum + psg_pkg::SAMPLE_W'(psg_pkg::level(attenuation[i]));
      end
    end
  end

  // Tone period write and its reload value, zero meaning 1024
  always_comb begin
    if (q_op.latch) begin
      tone_next = {tone_period[q_op.chan][9:4], q_op.value[3:0]};
    end else begin
      tone_next = {q_op.value, tone_period[q_op.chan][3:0]};
    end
    tone_reload = (tone_next == '0) ? psg_pkg::TONE_ZERO_PERIOD
                                    : psg_pkg::CNT_W'(tone_next);
  end

  // Noise period for a noise-control write
  always_comb begin
    case (q_op.value[1:0])
      2'd0:    noise_reload = psg_pkg::NOISE_PER_32;
      2'd1:    noise_reload = psg_pkg::NOISE_PER_64;
      2'd2:    noise_reload = psg_pkg::NOISE_PER_128;
      default: noise_reload = {reload_period[2][psg_pkg::CNT_W-2:0], 1'b0};
    endcase
  end

  // Generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        tone_period[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        reload_period[i] <= '0;
        down_counter[i]  <= '0;
        attenuation[i]   <= 4'hf;
      end
      channel_level <= '0;
      noise_control <= '0;
      noise_shift   <= psg_pkg::NOISE_SEED;
    end else if (do_op) begin
      case (q_op.kind)
        psg_pkg::OP_TICK: begin
          for (int i = 0; i < 4; i++) begin
            down_counter[i] <= cnt_next[i];
          end
          channel_level <= level_next;
          noise_shift   <= shift_next;
        end
        psg_pkg::OP_TONE: begin
          tone_period[q_op.chan]   <= tone_next;
          reload_period[q_op.chan] <= tone_reload;
          // noise tied to tone 2 follows its new period
          if (q_op.chan == psg_pkg::REG_TONE2[2:1] &&
              noise_control[1:0] == psg_pkg::NOISE_TIED) begin
            reload_period[3] <= {tone_reload[psg_pkg::CNT_W-2:0], 1'b0};
          end
        end
        psg_pkg::OP_NOISE: begin
          noise_control    <= q_op.value[3:0];
          reload_period[3] <= noise_reload;
          noise_shift      <= psg_pkg::NOISE_SEED;
        end
        default: begin
          attenuation[q_op.chan] <= q_op.value[3:0];
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_op && is_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_op && is_tick) begin
      m_tdata <= negate_output ? ('0 - sum) : sum;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(pop && is_tick))
    else $error("tick executed over a waiting sample");

  a_noise_reseed: assert property (@(posedge clk) disable iff (rst)
    pop && q_op.kind == psg_pkg::OP_NOISE |=> noise_shift == psg_pkg::NOISE_SEED)
    else $error("noise register not reseeded");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    pop && !is_tick && !m_tvalid |=> !m_tvalid)
    else $error("register write produced a sample");

endmodule

// ===== rtl/psg_tone_noise_generator_core.sv =====
// Top level of the three-tone, one-noise sound generator.
//
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   s_tdata = write_data, s_tuser = mode
//  m_*      out        m_tvalid / m_tready   m_tdata = sample (signed)
//  cfg_*    in         cfg_valid / cfg_ready cfg_data = negate_output
//
// One item per cycle unless stalled: the front decodes an item in its cycle of
// acceptance, the back executes one queued item per cycle while no waiting sample
// holds a tick, and a tick's sample is loaded into the output register on its pop.
// Reset is synchronous and clears the control and generator registers.
// A waiting sample stalls only ticks in the back; the queue then fills and
// s_tready falls once it holds QUEUE_DEPTH items.
module psg_tone_noise_generator_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // write_data[7:0]
  input  logic [0:0]   s_tuser,    // mode[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,    // sample[15:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data
);

  psg_pkg::op_t push_op;
  psg_pkg::op_t q_op;
  logic         push;
  logic         q_full;
  logic         q_valid;
  logic         pop;
  logic         negate_output;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      negate_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      negate_output <= cfg_data[0];
    end
  end

  psg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .op       (push_op)
  );

  psg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .out_valid (q_valid),
    .out_op    (q_op)
  );

  psg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .pop           (pop),
    .negate_output (negate_output),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
